>>> src/ins_sort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; imported by ins_sort_cell and insertion_sorter.
`timescale 1ns / 1ps
`default_nettype none

package ins_sort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the broadcast word into sorted position
        logic shift;    // move every entry one place toward cell 0
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/insertion_sorter.sv
// Top level of the streaming insertion sorter: cell chain plus emit control.
// Depends on ins_sort_pkg and ins_sort_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                                   | Word
// ---------+-------------------------------------------+--------------------------------
// input    | in_valid, in_ready, value, last           | one signed value, last of set
// output   | out_valid, out_ready, sorted_value,       | one value in ascending order
//          | end_of_set, truncated                     |
//
// Collect phase: one word per cycle; every cell compares against the
// broadcast word at once and greater entries step up one cell.
// A word marked last starts the emit phase: one result per cycle from cell 0
// while the chain shifts down; input is held off until the final result is
// loaded into the output register.
// Output stalls hold the output register and freeze the chain.
// Reset clears count, overflow, handshake state and the output word; cell
// contents stay undefined and are read only below the count.
module insertion_sorter
    import ins_sort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      sorted_value,
    output logic                          end_of_set,
    output logic                          truncated
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        COLLECT,
        EMIT
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            emit_cnt_reg;
    logic                     ovf_reg;
    logic                     trunc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] sorted_value_reg;
    logic                     end_of_set_reg;
    logic                     truncated_reg;

    logic      accept;
    logic      room;
    logic      out_load;
    cell_ctl_t ctl;

    logic signed [DATA_W-1:0] cell_data [MAX_ITEMS];
    logic                     cell_gt   [MAX_ITEMS];

    assign in_ready = (state_reg == COLLECT);
    assign accept   = in_valid && in_ready;
    assign room     = (count_reg < CW'(MAX_ITEMS));
    // In the emit phase, load the output register when it is empty or being drained this cycle
    assign out_load = (state_reg == EMIT) && (!out_valid_reg || out_ready);

    assign ctl.insert = accept && room;
    assign ctl.shift  = out_load;

    // Count after this word, including the word itself when it fits
    assign count_next = room ? (count_reg + CW'(1)) : count_reg;

    // The chain: cell 0 holds the smallest entry
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic                     left_g;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = value;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_end
            assign right_d = cell_data[i];
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        ins_sort_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .new_value  (value),
            .occupied   (count_reg > CW'(i)),
            .left_data  (left_d),
            .left_gt    (left_g),
            .right_data (right_d),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );
    end

    // Sequencer with registered output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= COLLECT;
            count_reg        <= '0;
            emit_cnt_reg     <= '0;
            ovf_reg          <= 1'b0;
            trunc_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            sorted_value_reg <= '0;
            end_of_set_reg   <= 1'b0;
            truncated_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                COLLECT:
                begin
                    if (accept)
                    begin
                        if (last)
                        begin
                            // Hand the set to the emit phase and empty the store
                            state_reg    <= EMIT;
                            emit_cnt_reg <= count_next;
                            trunc_reg    <= ovf_reg || !room;
                            count_reg    <= '0;
                            ovf_reg      <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_next;
                            if (!room)
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end
                end
                EMIT:
                begin
                    if (out_load)
                    begin
                        emit_cnt_reg <= emit_cnt_reg - CW'(1);
                        if (emit_cnt_reg == CW'(1))
                        begin
                            state_reg <= COLLECT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= COLLECT;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                sorted_value_reg <= cell_data[0];
                end_of_set_reg   <= (emit_cnt_reg == CW'(1));
                truncated_reg    <= trunc_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_of_set_reg;
    assign truncated    = truncated_reg;

endmodule

`default_nettype wire

>>> src/ins_sort_cell.sv
// One storage cell of the insertion chain.
// Depends on ins_sort_pkg (cell_ctl_t, DATA_W).
`timescale 1ns / 1ps
`default_nettype none

module ins_sort_cell
    import ins_sort_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic signed [DATA_W-1:0] new_value,
    input  wire logic                     occupied,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic                     left_gt,
    input  wire logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0]      data,
    output logic                          gt
);

    logic signed [DATA_W-1:0] data_reg;

    // Held entry is live and strictly greater than the incoming word
    assign gt   = occupied && (data_reg > new_value);
    assign data = data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= right_data;
        end
        else if (ctl.insert)
        begin
            if (left_gt)
            begin
                data_reg <= left_data;
            end
            else if (gt || !occupied)
            begin
                data_reg <= new_value;
            end
        end
    end

endmodule

`default_nettype wire
